// ===== src/wbm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbm_pkg: shared types and constants of the weighted bin merger
// Fixed-point constants, sequencer states, iterative unit request/response
// types and the saturating adders used by the accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

package wbm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VALUE_W    = 32;
    localparam int ERROR_W    = 32;
    localparam int SCALE_W    = 16;
    localparam int MERGED_W   = 40;
    localparam int ACC_W      = 64;
    localparam int STEP_CNT_W = 7;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // Numerator of the reciprocal weight, 2^(3F).
    localparam logic [ACC_W-1:0] POW_NUM = ACC_W'(64'd1 << (3 * FRAC_BITS));

    localparam logic signed [ACC_W-1:0] MERGED_MAX = 64'sd549755813887;
    localparam logic signed [ACC_W-1:0] MERGED_MIN = -64'sd549755813888;
    localparam logic signed [ACC_W-1:0] ACC_MAX    = 64'sd9223372036854775807;
    localparam logic signed [ACC_W-1:0] ACC_MIN    = -64'sd9223372036854775807;
    localparam logic [ACC_W-1:0] U32_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam logic [ACC_W-1:0] NEG_LIMIT = 64'h0000_0080_0000_0000;
    localparam logic [ACC_W-1:0] POS_LIMIT = 64'h0000_007F_FFFF_FFFF;

    localparam logic MODE_SUM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ES,
        ST_SCALE,
        ST_MUL_UU,
        ST_ACC,
        ST_WDIV,
        ST_MUL_VW,
        ST_WACC,
        ST_CLOSE,
        ST_MDIV,
        ST_EDIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed {
        logic             start;
        iter_op_t         op;
        logic [ACC_W-1:0] operand_a;
        logic [ACC_W-1:0] operand_b;
    } iter_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] result;
    } iter_rsp_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             clip;
    } sat_res_t;

    // Signed add that clips only in the direction the addend pushes.
    function automatic sat_res_t sat_add_s(input logic signed [ACC_W-1:0] a,
                                           input logic signed [ACC_W-1:0] b,
                                           input logic signed [ACC_W-1:0] lo,
                                           input logic signed [ACC_W-1:0] hi);
        logic signed [ACC_W+1:0] sum;
        sat_res_t r;
        sum = (ACC_W+2)'(a) + (ACC_W+2)'(b);
        r.value = sum[ACC_W-1:0];
        r.clip  = 1'b0;
        if (b > 0 && sum > (ACC_W+2)'(hi)) begin
            r.value = hi;
            r.clip  = 1'b1;
        end else if (b < 0 && sum < (ACC_W+2)'(lo)) begin
            r.value = lo;
            r.clip  = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_res_t sat_add_u(input logic [ACC_W-1:0] a,
                                           input logic [ACC_W-1:0] b);
        logic [ACC_W:0] sum;
        sat_res_t r;
        sum = {1'b0, a} + {1'b0, b};
        r.value = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        r.clip  = sum[ACC_W];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/weighted_bin_merger.sv =====
// ----------------------------------------------------------------------------
// weighted_bin_merger: merges one histogram bin over several measurements
// Input beats on s_* carry value, error and error scale; s_tlast closes the
// bin and produces one result beat on m_*. cfg_we/cfg_wdata set the mode:
// 0 inverse-variance weighted mean, 1 plain sum with quadrature errors.
// The block takes one beat at a time; s_tready is low while it works.
// In average mode a beat with a nonzero scaled error also runs the 64-step
// divider that forms the weight 2^48 / u^2; sum mode and a zero scaled error
// skip it. A closing beat adds a square root and the output load in sum mode,
// or two divisions, a square root and the output load in average mode, all
// on the one shared iterative unit.
// One 33x33 multiplier is reused for e*s, u*u and v*w.
// The result sits in an output register; further non-closing beats are
// accepted while it waits. A closing beat holds in its last step until the
// receiver has taken the previous result.
// Reset clears the accumulators, the clip flag, the mode and m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_bin_merger (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bin_value[31:0], bin_error[63:32], error_scale[79:64]
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // merged_value[39:0], merged_error[71:40]
    output logic [71:0]      m_tdata,
    // no_weight[0], saturated[1]
    output logic [1:0]       m_tuser
);
    import wbm_pkg::*;

    state_t state_reg, state_next;

    logic                       mode_reg, mode_next;
    logic                       mode_item_reg, mode_item_next;
    logic signed [VALUE_W-1:0]  v_reg, v_next;
    logic [ERROR_W-1:0]         e_reg, e_next;
    logic [SCALE_W-1:0]         s_reg, s_next;
    logic                       last_reg, last_next;
    logic [ERROR_W-1:0]         u_reg, u_next;
    logic [ERROR_W-1:0]         w_reg, w_next;
    logic [ACC_W-1:0]           prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc1_reg, acc1_next;
    logic [ACC_W-1:0]           acc2_reg, acc2_next;
    logic                       clip_reg, clip_next;
    logic                       nw_reg, nw_next;
    logic [MERGED_W-1:0]        val_reg, val_next;
    logic [ERROR_W-1:0]         err_reg, err_next;

    logic                       m_valid_reg, m_valid_next;
    logic [71:0]                m_data_reg, m_data_next;
    logic [1:0]                 m_user_reg, m_user_next;

    logic signed [VALUE_W:0]    mul_a, mul_b;
    logic signed [2*VALUE_W+1:0] mul_p;

    iter_req_t req;
    iter_rsp_t rsp;

    logic [48:0]      scaled;
    logic [40:0]      u_full;
    sat_res_t         add1, add2;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] q;

    wbm_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign mul_p    = mul_a * mul_b;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        mode_item_next = mode_item_reg;
        v_next         = v_reg;
        e_next         = e_reg;
        s_next         = s_reg;
        last_next      = last_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        acc1_next      = acc1_reg;
        acc2_next      = acc2_reg;
        clip_next      = clip_reg;
        nw_next        = nw_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        mul_a          = '0;
        mul_b          = '0;
        req            = '0;
        scaled         = {1'b0, prod_reg[47:0]} + 49'd128;
        u_full         = scaled[48:8];
        add1           = '0;
        add2           = '0;
        mag            = acc1_reg[ACC_W-1] ? ACC_W'(-acc1_reg) : acc1_reg;
        lim            = acc1_reg[ACC_W-1] ? NEG_LIMIT : POS_LIMIT;
        q              = rsp.result;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    v_next         = s_tdata[31:0];
                    e_next         = s_tdata[63:32];
                    s_next         = s_tdata[79:64];
                    last_next      = s_tlast;
                    mode_item_next = mode_reg;
                    state_next     = ST_MUL_ES;
                end
            end
            ST_MUL_ES: begin
                mul_a      = {1'b0, e_reg};
                mul_b      = {17'b0, s_reg};
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                // Round the Q8.8 scale product half up, clip to 32 bits.
                if (|u_full[40:32]) begin
                    u_next    = '1;
                    clip_next = 1'b1;
                end else begin
                    u_next = u_full[31:0];
                end
                state_next = ST_MUL_UU;
            end
            ST_MUL_UU: begin
                mul_a      = {1'b0, u_reg};
                mul_b      = {1'b0, u_reg};
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (mode_item_reg == MODE_SUM) begin
                    add1       = sat_add_s(acc1_reg, ACC_W'(v_reg), MERGED_MIN, MERGED_MAX);
                    add2       = sat_add_u(acc2_reg, prod_reg);
                    acc1_next  = add1.value;
                    acc2_next  = add2.value;
                    clip_next  = clip_reg | add1.clip | add2.clip;
                    state_next = ST_CLOSE;
                end else if (prod_reg == '0) begin
                    state_next = ST_CLOSE;
                end else begin
                    req.start     = 1'b1;
                    req.op        = OP_DIV;
                    req.operand_a = POW_NUM;
                    req.operand_b = prod_reg;
                    state_next    = ST_WDIV;
                end
            end
            ST_WDIV: begin
                if (rsp.done) begin
                    if (q > U32_LIMIT) begin
                        w_next    = '1;
                        clip_next = 1'b1;
                    end else begin
                        w_next = q[31:0];
                    end
                    state_next = ST_MUL_VW;
                end
            end
            ST_MUL_VW: begin
                mul_a      = {v_reg[VALUE_W-1], v_reg};
                mul_b      = {1'b0, w_reg};
                state_next = ST_WACC;
            end
            ST_WACC: begin
                add1       = sat_add_s(acc1_reg, prod_reg, ACC_MIN, ACC_MAX);
                add2       = sat_add_u(acc2_reg, {32'b0, w_reg});
                acc1_next  = add1.value;
                acc2_next  = add2.value;
                clip_next  = clip_reg | add1.clip | add2.clip;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                nw_next = 1'b0;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (mode_item_reg == MODE_SUM) begin
                    if (acc1_reg > MERGED_MAX) begin
                        val_next  = MERGED_MAX[MERGED_W-1:0];
                        clip_next = 1'b1;
                    end else if (acc1_reg < MERGED_MIN) begin
                        val_next  = MERGED_MIN[MERGED_W-1:0];
                        clip_next = 1'b1;
                    end else begin
                        val_next = acc1_reg[MERGED_W-1:0];
                    end
                    req.start     = 1'b1;
                    req.op        = OP_SQRT;
                    req.operand_a = acc2_reg;
                    state_next    = ST_SQRT;
                end else if (acc2_reg == '0) begin
                    nw_next    = 1'b1;
                    val_next   = '0;
                    err_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    req.start     = 1'b1;
                    req.op        = OP_DIV;
                    req.operand_a = mag;
                    req.operand_b = acc2_reg;
                    state_next    = ST_MDIV;
                end
            end
            ST_MDIV: begin
                if (rsp.done) begin
                    if (q > lim) begin
                        q         = lim;
                        clip_next = 1'b1;
                    end
                    val_next      = acc1_reg[ACC_W-1] ? -q[MERGED_W-1:0] : q[MERGED_W-1:0];
                    req.start     = 1'b1;
                    req.op        = OP_DIV;
                    req.operand_a = POW_NUM;
                    req.operand_b = acc2_reg;
                    state_next    = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (rsp.done) begin
                    req.start     = 1'b1;
                    req.op        = OP_SQRT;
                    req.operand_a = rsp.result;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (rsp.done) begin
                    err_next   = rsp.result[ERROR_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {err_reg, val_reg};
                    m_user_next  = {clip_reg, nw_reg};
                    acc1_next    = '0;
                    acc2_next    = '0;
                    clip_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    assign prod_next = mul_p[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            acc1_reg    <= '0;
            acc2_reg    <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            acc1_reg    <= acc1_next;
            acc2_reg    <= acc2_next;
            clip_reg    <= clip_next;
            m_valid_reg <= m_valid_next;
        end
        mode_item_reg <= mode_item_next;
        v_reg         <= v_next;
        e_reg         <= e_next;
        s_reg         <= s_next;
        last_reg      <= last_next;
        u_reg         <= u_next;
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        nw_reg        <= nw_next;
        val_reg       <= val_next;
        err_reg       <= err_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== src/wbm_iter.sv =====
// ----------------------------------------------------------------------------
// wbm_iter: shared iterative divide / square root unit
// One compare-and-subtract per cycle: restoring division of two 64-bit
// operands in 64 steps, or an integer square root of a 64-bit word in 32.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_iter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wbm_pkg::iter_req_t req,
    output wbm_pkg::iter_rsp_t      rsp
);
    import wbm_pkg::*;

    iter_op_t              op_reg, op_next;
    logic [ACC_W-1:0]      num_reg, num_next;
    logic [ACC_W-1:0]      den_reg, den_next;
    logic [ACC_W-1:0]      quo_reg, quo_next;
    logic [ACC_W:0]        rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [ACC_W:0]   rem_sh;
    logic [ACC_W:0]   trial;
    logic [ACC_W-1:0] num_sh;
    logic [ACC_W+1:0] diff;
    logic             ge;

    always_comb begin
        unique case (op_reg)
            OP_DIV: begin
                rem_sh = {rem_reg[ACC_W-1:0], num_reg[ACC_W-1]};
                trial  = {1'b0, den_reg};
                num_sh = {num_reg[ACC_W-2:0], 1'b0};
            end
            OP_SQRT: begin
                // Bring down two bits, try (root << 2) | 1.
                rem_sh = {rem_reg[ACC_W-2:0], num_reg[ACC_W-1:ACC_W-2]};
                trial  = {quo_reg[ACC_W-2:0], 2'b01};
                num_sh = {num_reg[ACC_W-3:0], 2'b00};
            end
        endcase
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = ~diff[ACC_W+1];

        op_next   = op_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (busy_reg) begin
            num_next = num_sh;
            rem_next = ge ? diff[ACC_W:0] : rem_sh;
            quo_next = {quo_reg[ACC_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            op_next   = req.op;
            num_next  = req.operand_a;
            den_next  = req.operand_b;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = (req.op == OP_DIV) ? STEP_CNT_W'(DIV_STEPS) : STEP_CNT_W'(SQRT_STEPS);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg   <= OP_DIV;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

endmodule

`default_nettype wire

// ===== src/wbm_checker.sv =====
// ----------------------------------------------------------------------------
// wbm_checker: port-level checks of the weighted bin merger
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A result beat waits until it is taken.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped before it was taken");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Each accepted beat leaves the input side busy in the cycle after it.
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // With no weight gathered, value and error are both zero.
    a_no_weight_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 72'd0)
        else $error("no_weight result with nonzero data");

    // A new result is only loaded while the input side is busy.
    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

endmodule

bind weighted_bin_merger wbm_checker u_wbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/weighted_bin_merger_tb.sv =====
// ----------------------------------------------------------------------------
// weighted_bin_merger_tb: self-checking testbench of the weighted bin merger
// Drives measurement beats with random gaps, predicts each closing result in
// a scoreboard class that models the fixed-point accumulation of both modes,
// and compares every result beat field by field under random receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_bin_merger_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wbm_pkg::*;

    typedef struct {
        logic [39:0] value;
        logic [31:0] err;
        logic        no_weight;
        logic        saturated;
    } merged_t;

    class bin_scoreboard;
        logic               sum_mode;
        logic signed [63:0] acc_a;
        logic [63:0]        acc_b;
        logic               clip;
        merged_t            pending[$];
        int                 errors;

        function new();
            sum_mode = 1'b0;
            acc_a = '0;
            acc_b = '0;
            clip = 1'b0;
            errors = 0;
        endfunction

        function void enqueue(merged_t m);
            pending.insert(pending.size(), m);
        endfunction

        // floor(2^48 / d), saturated at cap.
        function logic [63:0] recip(logic [63:0] d, logic [63:0] cap);
            logic [127:0] q;
            q = (128'd1 << 48) / {64'd0, d};
            if (q > {64'd0, cap}) begin
                clip = 1'b1;
                return cap;
            end
            return q[63:0];
        endfunction

        function logic [63:0] root(logic [63:0] x);
            logic [63:0] r;
            logic [127:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = {64'd0, r | (64'd1 << b)};
                if (t * t <= {64'd0, x}) r = r | (64'd1 << b);
            end
            return r;
        endfunction

        function void add_s(logic signed [63:0] b, logic signed [63:0] lo,
                            logic signed [63:0] hi);
            logic signed [65:0] s;
            s = 66'(acc_a) + 66'(b);
            if (b > 0 && s > 66'(hi)) begin
                acc_a = hi;
                clip = 1'b1;
            end else if (b < 0 && s < 66'(lo)) begin
                acc_a = lo;
                clip = 1'b1;
            end else acc_a = s[63:0];
        endfunction

        function void add_u(logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, acc_b} + {1'b0, b};
            if (s[64]) begin
                acc_b = '1;
                clip = 1'b1;
            end else acc_b = s[63:0];
        endfunction

        function void note_measurement(logic [79:0] d, logic last);
            logic signed [63:0] v;
            logic [63:0] u, u2, w, mag, q, lim, er;
            logic neg;
            merged_t m;
            v = 64'($signed(d[31:0]));
            u = ({32'd0, d[63:32]} * {48'd0, d[79:64]} + 64'd128) >> 8;
            if (u > 64'hFFFF_FFFF) begin
                u = 64'hFFFF_FFFF;
                clip = 1'b1;
            end
            u2 = u * u;
            if (sum_mode) begin
                add_s(v, MERGED_MIN, MERGED_MAX);
                add_u(u2);
            end else if (u2 != 0) begin
                w = recip(u2, 64'hFFFF_FFFF);
                add_s(v * $signed(w), ACC_MIN, ACC_MAX);
                add_u(w);
            end
            if (!last) return;
            m.no_weight = 1'b0;
            m.value = '0;
            er = 0;
            if (sum_mode) begin
                if (acc_a > MERGED_MAX) begin
                    acc_a = MERGED_MAX;
                    clip = 1'b1;
                end else if (acc_a < MERGED_MIN) begin
                    acc_a = MERGED_MIN;
                    clip = 1'b1;
                end
                m.value = acc_a[39:0];
                er = root(acc_b);
            end else if (acc_b == 0) begin
                m.no_weight = 1'b1;
            end else begin
                neg = acc_a < 0;
                mag = neg ? -acc_a : acc_a;
                q = mag / acc_b;
                lim = neg ? NEG_LIMIT : POS_LIMIT;
                if (q > lim) begin
                    q = lim;
                    clip = 1'b1;
                end
                m.value = neg ? 40'(-q) : q[39:0];
                er = root(recip(acc_b, '1));
            end
            if (er > 64'hFFFF_FFFF) begin
                er = 64'hFFFF_FFFF;
                clip = 1'b1;
            end
            m.err = er[31:0];
            m.saturated = clip;
            enqueue(m);
            acc_a = '0;
            acc_b = '0;
            clip = 1'b0;
        endfunction

        function void check_result(logic [71:0] d, logic [1:0] u);
            merged_t m;
            if (pending.size() == 0) begin
                $display("%t unexpected result: actual %h/%b", $realtime, d, u);
                errors++;
                return;
            end
            m = pending.pop_front();
            if (d[39:0] !== m.value) begin
                $display("%t merged_value: expected %h actual %h", $realtime, m.value, d[39:0]);
                errors++;
            end
            if (d[71:40] !== m.err) begin
                $display("%t merged_error: expected %h actual %h", $realtime, m.err, d[71:40]);
                errors++;
            end
            if (u[0] !== m.no_weight) begin
                $display("%t no_weight: expected %b actual %b", $realtime, m.no_weight, u[0]);
                errors++;
            end
            if (u[1] !== m.saturated) begin
                $display("%t saturated: expected %b actual %b", $realtime, m.saturated, u[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bin_scoreboard board = new();

    weighted_bin_merger dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // s_tvalid stays high after an accepted beat; the next call either
    // replaces the beat or drops s_tvalid while it idles.
    task automatic send_measurement(logic [31:0] v, logic [31:0] e, logic [15:0] s,
                                    logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s, e, v};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_measurement({s, e, v}, last);
    endtask

    // Mode is written only once every result is out and the block has drained.
    task automatic set_mode(logic m);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.sum_mode = m;
    endtask

    function automatic logic [31:0] pick_error();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(3);
            3: return $urandom_range(32'h0003_0000, 32'h0000_4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd256;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic random_bin(bit long_bin, output int n);
        n = long_bin ? $urandom_range(40, 17) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            send_measurement($urandom, pick_error(), pick_scale(), i == n - 1);
    endtask

    initial begin
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero weight, extremes, a tiny error that clips the weight.
        send_measurement(32'h7FFF_FFFF, 32'd0, 16'd256, 1'b1);
        send_measurement(32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_measurement(32'h7FFF_FFFF, 32'd1, 16'd1, 1'b1);
        send_measurement(32'h0001_0000, 32'h0001_0000, 16'd256, 1'b0);
        send_measurement(32'hFFFF_0000, 32'h0002_0000, 16'd256, 1'b1);
        for (int i = 0; i < 4; i++)
            send_measurement(32'h8000_0000, 32'd1, 16'd128, i == 3);
        set_mode(1'b1);
        send_measurement(32'h0000_0000, 32'd0, 16'd0, 1'b1);
        for (int i = 0; i < 4; i++)
            send_measurement(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, i == 3);
        for (int i = 0; i < 3; i++)
            send_measurement(32'h8000_0000, 32'h0000_8000, 16'd512, i == 2);
        // Mode switched inside a bin: the closing beat's mode forms the result.
        send_measurement(32'h0003_0000, 32'h0001_0000, 16'd256, 1'b0);
        set_mode(1'b0);
        send_measurement(32'h0001_0000, 32'h0001_0000, 16'd256, 1'b1);

        sent = 19;
        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph[0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            while (sent < 25 + 178 * (ph + 1)) begin
                int n;
                random_bin($urandom_range(19) == 0, n);
                sent += n;
            end
        end
        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
